// ===== hdl/stl_pkg.sv =====
// Package for the source token lexer: item types, mode codes, token classes,
// the keyword table and the small arithmetic helpers used by the step logic.
// No dependencies.
package stl_pkg;

  localparam int unsigned DefMaxTokenLen = 256;
  localparam int unsigned NumKeywords    = 16;
  localparam int unsigned KwMaxLen       = 7;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       at_end;
  } in_item_t;

  typedef struct packed {
    logic              record_kind;
    logic [3:0]        token_class;
    logic [4:0]        keyword_index;
    logic [7:0]        char_value;
    logic signed [31:0] number_value;
    logic [15:0]       start_line;
    logic [15:0]       start_column;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_COMMENT, MODE_DASH, MODE_PAREN, MODE_NSTART, MODE_NWORD,
    MODE_NDELIM, MODE_PREFIX, MODE_NUM, MODE_NEG, MODE_WVAR, MODE_WTYPE,
    MODE_WNULL, MODE_WAT
  } mode_e;

  typedef enum logic [1:0] {PFX_NONE, PFX_AT, PFX_DOLLAR} prefix_e;
  typedef enum logic [1:0] {NAT_NONE, NAT_PAREN, NAT_BRACE} native_e;
  typedef enum logic [1:0] {NL_NONE, NL_BREAK, NL_INNER} newline_e;

  localparam logic [3:0] CLS_END     = 4'd0;
  localparam logic [3:0] CLS_PUNCT   = 4'd1;
  localparam logic [3:0] CLS_UNIT    = 4'd2;
  localparam logic [3:0] CLS_ARROW   = 4'd3;
  localparam logic [3:0] CLS_NUMBER  = 4'd4;
  localparam logic [3:0] CLS_NATIVE  = 4'd5;
  localparam logic [3:0] CLS_VAR     = 4'd6;
  localparam logic [3:0] CLS_TYPE    = 4'd7;
  localparam logic [3:0] CLS_NULL    = 4'd8;
  localparam logic [3:0] CLS_KEYWORD = 4'd9;
  localparam logic [3:0] CLS_ERROR   = 4'd10;

  localparam logic [7:0] KW_TEXT [NumKeywords][KwMaxLen] = '{
    '{"b", "r", "e", "a", "k", 8'h0, 8'h0},
    '{"c", "a", "l", "l", 8'h0, 8'h0, 8'h0},
    '{"e", "l", "s", "e", 8'h0, 8'h0, 8'h0},
    '{"f", "u", "n", "c", 8'h0, 8'h0, 8'h0},
    '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"i", "n", "p", "u", "t", 8'h0, 8'h0},
    '{"l", "o", "o", "p", 8'h0, 8'h0, 8'h0},
    '{"n", "a", "t", "i", "v", "e", 8'h0},
    '{"o", "u", "t", "p", "u", "t", 8'h0},
    '{"p", "r", "e", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"r", "e", "t", "u", "r", "n", 8'h0},
    '{"s", "e", "t", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"t", "y", "p", "e", 8'h0, 8'h0, 8'h0},
    '{"v", "a", "r", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"@", "p", "t", "r", 8'h0, 8'h0, 8'h0},
    '{"@", "r", "e", "c", 8'h0, 8'h0, 8'h0}
  };
  localparam logic [2:0] KW_LEN [NumKeywords] = '{
    3'd5, 3'd4, 3'd4, 3'd4, 3'd2, 3'd5, 3'd4, 3'd6,
    3'd6, 3'd3, 3'd6, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return (c >= "A") && (c <= "Z");
  endfunction

  function automatic logic is_wordc(logic [7:0] c);
    return is_digit(c) || is_lower(c) || is_upper(c) || (c == "_");
  endfunction

  // Drops every candidate whose spelling does not continue with c at position p.
  function automatic logic [NumKeywords-1:0] kw_feed(logic [NumKeywords-1:0] cand,
                                                     logic [2:0] p, logic [7:0] c);
    logic [NumKeywords-1:0] res;
    res = cand;
    for (int k = 0; k < NumKeywords; k++) begin
      if (p >= KW_LEN[k] || KW_TEXT[k][p] != c) res[k] = 1'b0;
    end
    return res;
  endfunction

  // Adds one decimal digit; once past the signed range it sticks at 2^31.
  function automatic logic [31:0] accumulate(logic [31:0] acc, logic [7:0] c);
    logic [3:0]  d;
    logic [31:0] res;
    d = c[3:0];
    if (acc > 32'd214748364 || (acc == 32'd214748364 && d > 4'd8)) begin
      res = 32'h8000_0000;
    end else begin
      res = (acc << 3) + (acc << 1) + {28'd0, d};
    end
    return res;
  endfunction

  function automatic out_item_t mk(logic kind, logic [3:0] cls, logic [4:0] kw,
                                   logic [7:0] ch, logic [31:0] num,
                                   logic [15:0] ln, logic [15:0] cl);
    out_item_t r;
    r.record_kind   = kind;
    r.token_class   = cls;
    r.keyword_index = kw;
    r.char_value    = ch;
    r.number_value  = num;
    r.start_line    = ln;
    r.start_column  = cl;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

// ===== hdl/source_token_lexer.sv =====
// Flow: an accepted byte is registered, processed from the input register, and its
// results are written into a four-entry result queue, which offers them at the output.
// Throughput: one byte per cycle while the queue has room; a byte yields up to two
// results, and the queue stalls the input when fewer than two places are free.
// Reset: asynchronous, active low; the lexer returns to between tokens at line 1,
// column 1 and the result queue empties.
module source_token_lexer #(
  parameter int unsigned MAX_TOKEN_LEN = stl_pkg::DefMaxTokenLen
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stl_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stl_pkg::out_item_t  out_data_o
);
  import stl_pkg::*;

  localparam int unsigned TlW = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [TlW-1:0] TlLimit = TlW'(MAX_TOKEN_LEN - 1);

  // Input register.
  logic     in_vld_q;
  in_item_t in_q;
  logic     fire;

  // Lexer state.
  mode_e                  mode_q, mode_d;
  prefix_e                pfx_q, pfx_d;
  logic [NumKeywords-1:0] cand_q, cand_d;
  logic [2:0]             mpos_q, mpos_d;
  logic [TlW-1:0]         tlen_q, tlen_d;
  logic [31:0]            acc_q, acc_d;
  logic                   neg_q, neg_d;
  native_e                nopen_q, nopen_d;
  logic [TlW-1:0]         ndep_q, ndep_d;
  logic [15:0]            line_q, line_d, col_q, col_d;
  logic [15:0]            tline_q, tline_d, tcol_q, tcol_d;

  // Result queue.
  out_item_t fifo_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;

  out_item_t res [2];
  logic [1:0] rcnt;

  assign fire       = in_vld_q && (cnt_q <= 3'd2);
  assign in_stall_o = in_vld_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_comb begin
    logic [7:0]  c;
    logic        do_idle;
    newline_e    nlk;
    logic        hit;
    logic [31:0] v;
    c       = in_q.char_byte;
    do_idle = 1'b0;
    nlk     = NL_NONE;
    hit     = 1'b0;
    v       = '0;
    mode_d  = mode_q;  pfx_d   = pfx_q;   cand_d  = cand_q;  mpos_d = mpos_q;
    tlen_d  = tlen_q;  acc_d   = acc_q;   neg_d   = neg_q;
    nopen_d = nopen_q; ndep_d  = ndep_q;
    line_d  = line_q;  col_d   = col_q;   tline_d = tline_q; tcol_d = tcol_q;
    rcnt    = 2'd0;
    res[0]  = mk(1'b0, CLS_END, 5'd0, 8'd0, 32'd0, 16'd0, 16'd0);
    res[1]  = res[0];

    if (in_q.at_end) begin
      unique case (mode_q)
        MODE_DASH: begin
          res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, "-", 32'd0, tline_d, tcol_d);
          rcnt = rcnt + 2'd1;
        end
        MODE_PAREN: begin
          res[rcnt[0]] = mk(1'b1, CLS_PUNCT, 5'd0, "(", 32'd0, tline_d, tcol_d);
          rcnt = rcnt + 2'd1;
        end
        MODE_NSTART, MODE_NWORD: begin
          res[rcnt[0]] = mk(1'b1, CLS_NATIVE, 5'd0, 8'd0, 32'd0, tline_d, tcol_d);
          rcnt = rcnt + 2'd1;
        end
        MODE_NDELIM: begin
          res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, 8'd0, 32'd0, tline_d, tcol_d);
          rcnt = rcnt + 2'd1;
        end
        MODE_PREFIX: begin
          res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, (pfx_q == PFX_AT) ? 8'h40 : 8'd0,
                            32'd0, tline_d, tcol_d);
          rcnt = rcnt + 2'd1;
        end
        MODE_NUM, MODE_NEG: begin
          if (neg_q) v = 32'd0 - acc_q;
          else v = (acc_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc_q;
          res[rcnt[0]] = mk(1'b1, CLS_NUMBER, 5'd0, 8'd0, v, tline_d, tcol_d);
          rcnt = rcnt + 2'd1;
        end
        MODE_WVAR, MODE_WTYPE, MODE_WNULL, MODE_WAT: begin
          for (int k = NumKeywords - 1; k >= 0; k--) begin
            if (cand_q[k] && KW_LEN[k] == mpos_q) begin
              hit = 1'b1;
              v   = 32'(k);
            end
          end
          res[rcnt[0]] = mk(1'b1, hit ? CLS_KEYWORD :
                            (mode_q == MODE_WVAR)  ? CLS_VAR :
                            (mode_q == MODE_WTYPE) ? CLS_TYPE :
                            (mode_q == MODE_WNULL) ? CLS_NULL : CLS_ERROR,
                            hit ? v[4:0] : 5'd0, 8'd0, 32'd0, tline_d, tcol_d);
          rcnt = rcnt + 2'd1;
        end
        default: ;
      endcase
      mode_d = MODE_IDLE;
      pfx_d  = PFX_NONE;
      res[rcnt[0]] = mk(1'b1, CLS_END, 5'd0, 8'd0, 32'd0, line_q, col_q);
      rcnt = rcnt + 2'd1;
    end else begin
      unique case (mode_q)
        MODE_COMMENT: begin
          if (c == 8'h0A) do_idle = 1'b1;
        end
        MODE_DASH: begin
          if (c == "-") begin
            mode_d = MODE_COMMENT;
          end else if (c == ">") begin
            res[rcnt[0]] = mk(1'b1, CLS_ARROW, 5'd0, 8'd0, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            mode_d = MODE_IDLE;
          end else if (is_digit(c)) begin
            mode_d = MODE_NEG;
            neg_d  = 1'b1;
            acc_d  = accumulate(acc_d, c);
            if (tlen_d >= TlLimit) begin
              res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              mode_d = MODE_IDLE;
            end else begin
              res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, "-", 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              tlen_d = tlen_d + 1'b1;
              if (tlen_d >= TlLimit) begin
                res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
                rcnt = rcnt + 2'd1;
                mode_d = MODE_IDLE;
              end else begin
                res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, c, 32'd0, tline_d, tcol_d);
                rcnt = rcnt + 2'd1;
                tlen_d = tlen_d + 1'b1;
              end
            end
          end else begin
            res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, "-", 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_PAREN: begin
          if (c == ")") begin
            res[rcnt[0]] = mk(1'b1, CLS_UNIT, 5'd0, 8'd0, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            res[rcnt[0]] = mk(1'b1, CLS_PUNCT, 5'd0, "(", 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_NSTART, MODE_NWORD: begin
          if ((mode_q == MODE_NSTART) && (c == "(" || c == "{")) begin
            nopen_d = (c == "(") ? NAT_PAREN : NAT_BRACE;
            ndep_d  = TlW'(1);
            mode_d  = MODE_NDELIM;
          end else if (is_wordc(c)) begin
            mode_d = MODE_NWORD;
            if (tlen_d >= TlLimit) begin
              res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              mode_d = MODE_IDLE;
            end else begin
              res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              tlen_d = tlen_d + 1'b1;
            end
          end else begin
            res[rcnt[0]] = mk(1'b1, CLS_NATIVE, 5'd0, 8'd0, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_NDELIM: begin
          if (c == ((nopen_q == NAT_PAREN) ? "(" : "{")) begin
            ndep_d = ndep_d + 1'b1;
          end else if (c == ((nopen_q == NAT_PAREN) ? ")" : "}")) begin
            ndep_d = ndep_d - 1'b1;
          end
          if (ndep_d == '0) begin
            res[rcnt[0]] = mk(1'b1, CLS_NATIVE, 5'd0, 8'd0, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            mode_d = MODE_IDLE;
          end else if (tlen_d >= TlLimit) begin
            res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, c, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            tlen_d = tlen_d + 1'b1;
            if (c == 8'h0A) nlk = NL_INNER;
          end
        end
        MODE_PREFIX: begin
          if (pfx_q == PFX_AT) begin
            if (is_digit(c)) begin
              mode_d = MODE_NUM;
              acc_d  = accumulate(acc_d, c);
              if (tlen_d >= TlLimit) begin
                res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
                rcnt = rcnt + 2'd1;
                mode_d = MODE_IDLE;
              end else begin
                res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, c, 32'd0, tline_d, tcol_d);
                rcnt = rcnt + 2'd1;
                tlen_d = tlen_d + 1'b1;
              end
            end else if (is_wordc(c)) begin
              mode_d = MODE_WAT;
              cand_d = kw_feed(cand_d, mpos_d, 8'h40);
              if (mpos_d != 3'd7) mpos_d = mpos_d + 3'd1;
              cand_d = kw_feed(cand_d, mpos_d, c);
              if (mpos_d != 3'd7) mpos_d = mpos_d + 3'd1;
              if (tlen_d >= TlLimit) begin
                res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
                rcnt = rcnt + 2'd1;
                mode_d = MODE_IDLE;
              end else begin
                res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, 8'h40, 32'd0, tline_d, tcol_d);
                rcnt = rcnt + 2'd1;
                tlen_d = tlen_d + 1'b1;
                if (tlen_d >= TlLimit) begin
                  res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
                  rcnt = rcnt + 2'd1;
                  mode_d = MODE_IDLE;
                end else begin
                  res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, c, 32'd0, tline_d, tcol_d);
                  rcnt = rcnt + 2'd1;
                  tlen_d = tlen_d + 1'b1;
                end
              end
            end else begin
              res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, 8'h40, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              do_idle = 1'b1;
            end
          end else if (is_upper(c)) begin
            mode_d = MODE_WNULL;
            cand_d = kw_feed(cand_d, mpos_d, c);
            if (mpos_d != 3'd7) mpos_d = mpos_d + 3'd1;
            if (tlen_d >= TlLimit) begin
              res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              mode_d = MODE_IDLE;
            end else begin
              res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              tlen_d = tlen_d + 1'b1;
            end
          end else begin
            res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_NUM, MODE_NEG: begin
          if (is_digit(c)) begin
            acc_d = accumulate(acc_d, c);
            if (tlen_d >= TlLimit) begin
              res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              mode_d = MODE_IDLE;
            end else begin
              res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              tlen_d = tlen_d + 1'b1;
            end
          end else if ((mode_q == MODE_NUM) && (is_lower(c) || is_upper(c))) begin
            res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            if (neg_q) v = 32'd0 - acc_q;
            else v = (acc_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc_q;
            res[rcnt[0]] = mk(1'b1, CLS_NUMBER, 5'd0, 8'd0, v, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_WVAR, MODE_WTYPE, MODE_WNULL, MODE_WAT: begin
          if (is_wordc(c)) begin
            cand_d = kw_feed(cand_d, mpos_d, c);
            if (mpos_d != 3'd7) mpos_d = mpos_d + 3'd1;
            if (tlen_d >= TlLimit) begin
              res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              mode_d = MODE_IDLE;
            end else begin
              res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              tlen_d = tlen_d + 1'b1;
            end
          end else begin
            for (int k = NumKeywords - 1; k >= 0; k--) begin
              if (cand_q[k] && KW_LEN[k] == mpos_q) begin
                hit = 1'b1;
                v   = 32'(k);
              end
            end
            res[rcnt[0]] = mk(1'b1, hit ? CLS_KEYWORD :
                              (mode_q == MODE_WVAR)  ? CLS_VAR :
                              (mode_q == MODE_WTYPE) ? CLS_TYPE :
                              (mode_q == MODE_WNULL) ? CLS_NULL : CLS_ERROR,
                              hit ? v[4:0] : 5'd0, 8'd0, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // Handling of a byte between tokens, also for a byte that closed a token.
      if (do_idle) begin
        mode_d = MODE_IDLE;
        if (c == 8'h0A) begin
          nlk = NL_BREAK;
        end else if (c != " ") begin
          tline_d = line_q;  tcol_d  = col_q;
          tlen_d  = '0;      cand_d  = '1;       mpos_d = 3'd0;
          acc_d   = '0;      neg_d   = 1'b0;
          nopen_d = NAT_NONE; ndep_d = '0;       pfx_d  = PFX_NONE;
          if (c == "{" || c == "}" || c == ")" || c == ";" || c == ":" || c == "=" ||
              c == "," || c == "." || c == 8'h5C || c == "!" || c == "?") begin
            res[rcnt[0]] = mk(1'b1, CLS_PUNCT, 5'd0, c, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
          end else if (c == "(") begin
            mode_d = MODE_PAREN;
          end else if (c == "-") begin
            mode_d = MODE_DASH;
          end else if (c == "_") begin
            mode_d = MODE_NSTART;
          end else if (c == 8'h40) begin
            mode_d = MODE_PREFIX;
            pfx_d  = PFX_AT;
          end else if (c == "$") begin
            mode_d = MODE_PREFIX;
            pfx_d  = PFX_DOLLAR;
          end else if (is_digit(c) || is_lower(c) || is_upper(c)) begin
            if (is_digit(c)) begin
              mode_d = MODE_NUM;
              acc_d  = accumulate(32'd0, c);
            end else begin
              mode_d = is_lower(c) ? MODE_WVAR : MODE_WTYPE;
              cand_d = kw_feed(cand_d, 3'd0, c);
              mpos_d = 3'd1;
            end
            // The text length was just cleared, so only a tiny limit can trip here.
            if (tlen_d >= TlLimit) begin
              res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              mode_d = MODE_IDLE;
            end else begin
              res[rcnt[0]] = mk(1'b0, CLS_END, 5'd0, c, 32'd0, tline_d, tcol_d);
              rcnt = rcnt + 2'd1;
              tlen_d = tlen_d + 1'b1;
            end
          end else begin
            res[rcnt[0]] = mk(1'b1, CLS_ERROR, 5'd0, c, 32'd0, tline_d, tcol_d);
            rcnt = rcnt + 2'd1;
          end
        end
      end

      // Position tracking after the byte has been consumed.
      if (nlk == NL_BREAK) begin
        if (line_q != 16'hFFFF) line_d = line_q + 16'd1;
        col_d = 16'd1;
      end else begin
        if (nlk == NL_INNER && line_q != 16'hFFFF) line_d = line_q + 16'd1;
        if (col_q != 16'hFFFF) col_d = col_q + 16'd1;
      end
    end

    if (rcnt == 2'd1) res[0].last = 1'b1;
    if (rcnt == 2'd2) res[1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pfx_q   <= PFX_NONE;
      cand_q  <= '1;
      mpos_q  <= 3'd0;
      tlen_q  <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      nopen_q <= NAT_NONE;
      ndep_q  <= '0;
      line_q  <= 16'd1;
      col_q   <= 16'd1;
      tline_q <= 16'd1;
      tcol_q  <= 16'd1;
    end else if (fire) begin
      mode_q  <= mode_d;
      pfx_q   <= pfx_d;
      cand_q  <= cand_d;
      mpos_q  <= mpos_d;
      tlen_q  <= tlen_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      nopen_q <= nopen_d;
      ndep_q  <= ndep_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
    end
  end

  logic pop;
  assign pop         = (cnt_q != 3'd0) && !out_stall_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (fire && rcnt != 2'd0) fifo_q[wptr_q] <= res[0];
    if (fire && rcnt == 2'd2) fifo_q[wptr_q + 2'd1] <= res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 3'd0;
    end else begin
      if (fire) wptr_q <= wptr_q + rcnt;
      if (pop) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + (fire ? {1'b0, rcnt} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

endmodule

// ===== hdl/stl_checker.sv =====
// Port-level checks for the source token lexer, bound to the top level.
// Depends on stl_pkg.
module stl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input stl_pkg::out_item_t out_data_o
);
  import stl_pkg::*;

  // A stalled result transfer stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // Text items carry no class and no number.
  a_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.record_kind |->
      out_data_o.token_class == CLS_END && out_data_o.number_value == 32'sd0)
    else $error("text item with class or value");

  // Positions never fall to zero.
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.start_line != 16'd0 && out_data_o.start_column != 16'd0)
    else $error("zero position");

  // An end record always closes the results of its byte.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_kind && out_data_o.token_class == CLS_END |->
      out_data_o.last)
    else $error("end record not last");

endmodule

bind source_token_lexer stl_checker u_stl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== dv/source_token_lexer_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the source token lexer: a directed table followed by random
// byte streams, each result checked against an in-bench lexer model.
// Depends on stl_pkg and source_token_lexer.
module source_token_lexer_tb;
  import stl_pkg::*;

  localparam int MaxLen = 256;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  source_token_lexer uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // Lexer state held by the model.
  mode_e       md;
  logic [1:0]  pfx;
  logic [15:0] cand;
  logic [2:0]  mpos;
  int          tlen;
  logic [31:0] acc;
  logic        neg;
  logic [1:0]  nopen;
  int          depth;
  logic [15:0] lcnt, ccnt, tline, tcol;
  int          nl;

  out_item_t   step_res[$];
  out_item_t   pending_tokens[$];
  int          errors = 0;
  int          send_idle = 0, recv_stall = 0;

  function automatic void lx_emit(logic k, logic [3:0] cls, logic [4:0] kw,
                                  logic [7:0] ch, logic [31:0] num,
                                  logic [15:0] ln, logic [15:0] cl);
    out_item_t r;
    if (step_res.size() >= 2) return;
    r.record_kind = k; r.token_class = cls; r.keyword_index = kw;
    r.char_value = ch; r.number_value = num; r.start_line = ln;
    r.start_column = cl; r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void lx_rec(logic [3:0] cls, logic [4:0] kw, logic [7:0] ch,
                                 logic [31:0] num);
    lx_emit(1'b1, cls, kw, ch, num, tline, tcol);
  endfunction

  function automatic bit lx_text(logic [7:0] c);
    if (tlen + 1 >= MaxLen) return 1'b0;
    lx_emit(1'b0, CLS_END, 5'd0, c, 32'd0, tline, tcol);
    tlen++;
    return 1'b1;
  endfunction

  function automatic void lx_text_or_fail(logic [7:0] c);
    if (!lx_text(c)) begin
      lx_rec(CLS_ERROR, 5'd0, c, 32'd0);
      md = MODE_IDLE;
    end
  endfunction

  // Keyword table is spelled here independently of the package.
  function automatic void lx_kw(logic [7:0] c);
    string words[16] = '{"break", "call", "else", "func", "if", "input", "loop",
      "native", "output", "pre", "return", "set", "type", "var", "@ptr", "@rec"};
    for (int k = 0; k < 16; k++)
      if (cand[k] && (mpos >= words[k].len() || words[k][mpos] != c)) cand[k] = 1'b0;
    if (mpos < 7) mpos++;
  endfunction

  function automatic void lx_acc(logic [7:0] c);
    logic [31:0] d;
    d = c - 8'h30;
    if (acc > 32'd214748364 || (acc == 32'd214748364 && d > 8)) acc = 32'h8000_0000;
    else acc = acc * 10 + d;
  endfunction

  function automatic void lx_num();
    logic [31:0] v;
    if (neg) v = -acc;
    else v = (acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc;
    lx_rec(CLS_NUMBER, 5'd0, 8'd0, v);
  endfunction

  function automatic void lx_word();
    int lens[16] = '{5, 4, 4, 4, 2, 5, 4, 6, 6, 3, 6, 3, 4, 3, 4, 4};
    for (int k = 0; k < 16; k++)
      if (cand[k] && lens[k] == mpos) begin
        lx_rec(CLS_KEYWORD, k[4:0], 8'd0, 32'd0);
        return;
      end
    case (md)
      MODE_WVAR:  lx_rec(CLS_VAR, 5'd0, 8'd0, 32'd0);
      MODE_WTYPE: lx_rec(CLS_TYPE, 5'd0, 8'd0, 32'd0);
      MODE_WNULL: lx_rec(CLS_NULL, 5'd0, 8'd0, 32'd0);
      default:    lx_rec(CLS_ERROR, 5'd0, 8'd0, 32'd0);
    endcase
  endfunction

  function automatic bit is_dg(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
  function automatic bit is_lo(logic [7:0] c); return c >= "a" && c <= "z"; endfunction
  function automatic bit is_up(logic [7:0] c); return c >= "A" && c <= "Z"; endfunction
  function automatic bit is_wd(logic [7:0] c);
    return is_dg(c) || is_lo(c) || is_up(c) || c == "_";
  endfunction

  function automatic void lx_idle(logic [7:0] c);
    md = MODE_IDLE;
    if (c == " ") return;
    if (c == 8'h0A) begin nl = 1; return; end
    tline = lcnt; tcol = ccnt; tlen = 0; cand = 16'hFFFF; mpos = 0;
    acc = 0; neg = 0; nopen = 0; depth = 0; pfx = 0;
    case (c)
      "{", "}", ")", ";", ":", "=", ",", ".", "\\", "!", "?": begin
        lx_rec(CLS_PUNCT, 5'd0, c, 32'd0); return;
      end
      "(": begin md = MODE_PAREN; return; end
      "-": begin md = MODE_DASH; return; end
      "_": begin md = MODE_NSTART; return; end
      "@": begin md = MODE_PREFIX; pfx = 1; return; end
      "$": begin md = MODE_PREFIX; pfx = 2; return; end
      default: ;
    endcase
    if (is_dg(c)) begin md = MODE_NUM; lx_acc(c); lx_text_or_fail(c); end
    else if (is_lo(c)) begin md = MODE_WVAR; lx_kw(c); lx_text_or_fail(c); end
    else if (is_up(c)) begin md = MODE_WTYPE; lx_kw(c); lx_text_or_fail(c); end
    else lx_rec(CLS_ERROR, 5'd0, c, 32'd0);
  endfunction

  function automatic void lx_byte(logic [7:0] c);
    logic [7:0] opener, closer;
    case (md)
      MODE_COMMENT: if (c == 8'h0A) lx_idle(c);
      MODE_DASH:
        if (c == "-") md = MODE_COMMENT;
        else if (c == ">") begin lx_rec(CLS_ARROW, 5'd0, 8'd0, 32'd0); md = MODE_IDLE; end
        else if (is_dg(c)) begin
          md = MODE_NEG; neg = 1; lx_acc(c);
          if (!lx_text("-")) begin lx_rec(CLS_ERROR, 5'd0, c, 32'd0); md = MODE_IDLE; end
          else lx_text_or_fail(c);
        end else begin lx_rec(CLS_ERROR, 5'd0, "-", 32'd0); lx_idle(c); end
      MODE_PAREN:
        if (c == ")") begin lx_rec(CLS_UNIT, 5'd0, 8'd0, 32'd0); md = MODE_IDLE; end
        else begin lx_rec(CLS_PUNCT, 5'd0, "(", 32'd0); lx_idle(c); end
      MODE_NSTART:
        if (c == "(" || c == "{") begin
          nopen = (c == "(") ? 2'd1 : 2'd2; depth = 1; md = MODE_NDELIM;
        end else if (is_wd(c)) begin md = MODE_NWORD; lx_text_or_fail(c); end
        else begin lx_rec(CLS_NATIVE, 5'd0, 8'd0, 32'd0); lx_idle(c); end
      MODE_NWORD:
        if (is_wd(c)) lx_text_or_fail(c);
        else begin lx_rec(CLS_NATIVE, 5'd0, 8'd0, 32'd0); lx_idle(c); end
      MODE_NDELIM: begin
        opener = (nopen == 1) ? "(" : "{";
        closer = (nopen == 1) ? ")" : "}";
        if (c == opener) depth++;
        else if (c == closer) begin
          depth--;
          if (depth == 0) begin
            lx_rec(CLS_NATIVE, 5'd0, 8'd0, 32'd0); md = MODE_IDLE; return;
          end
        end
        if (!lx_text(c)) begin lx_rec(CLS_ERROR, 5'd0, c, 32'd0); md = MODE_IDLE; return; end
        if (c == 8'h0A) nl = 2;
      end
      MODE_PREFIX:
        if (pfx == 1) begin
          if (is_dg(c)) begin md = MODE_NUM; lx_acc(c); lx_text_or_fail(c); end
          else if (is_wd(c)) begin
            md = MODE_WAT; lx_kw("@"); lx_kw(c);
            if (!lx_text("@")) begin lx_rec(CLS_ERROR, 5'd0, c, 32'd0); md = MODE_IDLE; end
            else lx_text_or_fail(c);
          end else begin lx_rec(CLS_ERROR, 5'd0, "@", 32'd0); lx_idle(c); end
        end else begin
          if (is_up(c)) begin md = MODE_WNULL; lx_kw(c); lx_text_or_fail(c); end
          else begin lx_rec(CLS_ERROR, 5'd0, c, 32'd0); md = MODE_IDLE; end
        end
      MODE_NUM:
        if (is_dg(c)) begin lx_acc(c); lx_text_or_fail(c); end
        else if (is_lo(c) || is_up(c)) begin
          lx_rec(CLS_ERROR, 5'd0, c, 32'd0); md = MODE_IDLE;
        end else begin lx_num(); lx_idle(c); end
      MODE_NEG:
        if (is_dg(c)) begin lx_acc(c); lx_text_or_fail(c); end
        else begin lx_num(); lx_idle(c); end
      MODE_WVAR, MODE_WTYPE, MODE_WNULL, MODE_WAT:
        if (is_wd(c)) begin lx_kw(c); lx_text_or_fail(c); end
        else begin lx_word(); lx_idle(c); end
      default: lx_idle(c);
    endcase
  endfunction

  function automatic void lx_reset();
    md = MODE_IDLE; pfx = 0; cand = 16'hFFFF; mpos = 0; tlen = 0; acc = 0;
    neg = 0; nopen = 0; depth = 0; lcnt = 1; ccnt = 1; tline = 1; tcol = 1;
  endfunction

  // Runs one input through the model and queues what it should produce.
  function automatic void lex_item(in_item_t it);
    step_res.delete();
    if (it.at_end) begin
      case (md)
        MODE_DASH:   lx_rec(CLS_ERROR, 5'd0, "-", 32'd0);
        MODE_PAREN:  lx_rec(CLS_PUNCT, 5'd0, "(", 32'd0);
        MODE_NSTART, MODE_NWORD: lx_rec(CLS_NATIVE, 5'd0, 8'd0, 32'd0);
        MODE_NDELIM: lx_rec(CLS_ERROR, 5'd0, 8'd0, 32'd0);
        MODE_PREFIX: lx_rec(CLS_ERROR, 5'd0, (pfx == 1) ? 8'h40 : 8'h00, 32'd0);
        MODE_NUM, MODE_NEG: lx_num();
        MODE_WVAR, MODE_WTYPE, MODE_WNULL, MODE_WAT: lx_word();
        default: ;
      endcase
      md = MODE_IDLE; pfx = 0;
      lx_emit(1'b1, CLS_END, 5'd0, 8'd0, 32'd0, lcnt, ccnt);
    end else begin
      nl = 0;
      lx_byte(it.char_byte);
      if (nl == 1) begin
        if (lcnt < 16'hFFFF) lcnt++;
        ccnt = 1;
      end else begin
        if (nl == 2 && lcnt < 16'hFFFF) lcnt++;
        if (ccnt < 16'hFFFF) ccnt++;
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) pending_tokens.push_back(step_res[i]);
  endfunction

  // Directed stimulus: bytes and end marks, with a few results typed in.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } row_t;

  function automatic row_t rw(logic [7:0] b, logic e);
    row_t r;
    r.item.char_byte = b; r.item.at_end = e; r.typed = 1'b0; r.res = '0;
    return r;
  endfunction

  function automatic row_t rwx(logic [7:0] b, logic e, logic [3:0] cls,
                               logic [7:0] ch, logic [15:0] ln, logic [15:0] cl);
    row_t r;
    r = rw(b, e);
    r.typed = 1'b1;
    r.res = '{record_kind: 1'b1, token_class: cls, keyword_index: 5'd0,
              char_value: ch, number_value: 32'd0, start_line: ln,
              start_column: cl, last: 1'b1};
    return r;
  endfunction

  in_item_t send_q[$];

  task automatic push_str(string s);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.char_byte = s[i]; it.at_end = 1'b0; send_q.push_back(it);
    end
  endtask

  task automatic push_end();
    in_item_t it;
    it.char_byte = 8'($urandom); it.at_end = 1'b1; send_q.push_back(it);
  endtask

  // Sends one item and waits for its transfer; valid stays high between
  // back-to-back items and is dropped only for idle cycles.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lex_item(it);
  endtask

  // Checks each transfer on the result side.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        errors++;
      end else begin
        e = pending_tokens.pop_front();
        if (out_data_o.record_kind !== e.record_kind) begin
          $error("record_kind exp %0d got %0d", e.record_kind, out_data_o.record_kind); errors++; end
        if (out_data_o.token_class !== e.token_class) begin
          $error("token_class exp %0d got %0d", e.token_class, out_data_o.token_class); errors++; end
        if (out_data_o.keyword_index !== e.keyword_index) begin
          $error("keyword_index exp %0d got %0d", e.keyword_index, out_data_o.keyword_index);
          errors++; end
        if (out_data_o.char_value !== e.char_value) begin
          $error("char_value exp %0h got %0h", e.char_value, out_data_o.char_value); errors++; end
        if (out_data_o.number_value !== e.number_value) begin
          $error("number_value exp %0d got %0d", e.number_value, out_data_o.number_value);
          errors++; end
        if (out_data_o.start_line !== e.start_line) begin
          $error("start_line exp %0d got %0d", e.start_line, out_data_o.start_line); errors++; end
        if (out_data_o.start_column !== e.start_column) begin
          $error("start_column exp %0d got %0d", e.start_column, out_data_o.start_column);
          errors++; end
        if (out_data_o.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_data_o.last); errors++; end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall);
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  string frags[] = '{"break", "call", "else", "func", "if", "input", "loop", "native",
    "output", "pre", "return", "set", "type", "var", "@ptr", "@rec", "@foo", "@12",
    "@", "$Nil", "$x", "$", "_(a(b)c)", "_{x\n}", "_c_fn", "_", "()", "(", "->", "-",
    "-42", "-2147483649", "2147483648", "12a", "007", "-- note\n", "\n", " ", "Foo9",
    "x_1", "{", "}", ")", ";", ":", "=", ",", ".", "\\", "!", "?", "#", "\t"};

  initial begin
    row_t dir[$];
    in_item_t it;
    string s;
    int n;
    lx_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single punctuation at the very start, then the other special cases.
    dir.push_back(rwx(";", 1'b0, CLS_PUNCT, ";", 16'd1, 16'd1));
    dir.push_back(rwx(8'hFF, 1'b0, CLS_ERROR, 8'hFF, 16'd1, 16'd2));
    dir.push_back(rwx(8'h00, 1'b0, CLS_ERROR, 8'h00, 16'd1, 16'd3));
    dir.push_back(rw("@", 1'b0));
    dir.push_back(rwx(" ", 1'b0, CLS_ERROR, "@", 16'd1, 16'd4));
    dir.push_back(rw("$", 1'b0));
    dir.push_back(rwx("1", 1'b0, CLS_ERROR, "1", 16'd1, 16'd6));
    dir.push_back(rw("-", 1'b0));
    dir.push_back(rwx(" ", 1'b0, CLS_ERROR, "-", 16'd1, 16'd8));
    dir.push_back(rw("9", 1'b0));
    dir.push_back(rwx("z", 1'b0, CLS_ERROR, "z", 16'd1, 16'd10));
    dir.push_back(rw("_", 1'b0));
    dir.push_back(rw("(", 1'b0));
    dir.push_back(rw("\n", 1'b0));
    dir.push_back(rw("(", 1'b0));
    dir.push_back(rw(")", 1'b0));
    dir.push_back(rw(8'h80, 1'b0));
    dir.push_back(rw(8'h00, 1'b1));
    dir.push_back(rw(8'h55, 1'b1));
    foreach (dir[i]) begin
      send_item(dir[i].item);
      if (dir[i].typed && pending_tokens.size() > 0 &&
          pending_tokens[pending_tokens.size() - 1] !== dir[i].res) begin
        $error("directed row %0d model result %p differs from table", i,
               pending_tokens[pending_tokens.size() - 1]);
        errors++;
      end
    end

    // Random token streams; a few over-long tokens and raw noise mixed in.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 65; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 65; end
        default: begin send_idle = 9; recv_stall = 9; end
      endcase
      n = 0;
      while (n < 310) begin
        send_q.delete();
        case ($urandom_range(19))
          0: begin
            it.char_byte = 8'($urandom); it.at_end = 1'b0; send_q.push_back(it);
          end
          1: if ($urandom_range(3) == 0) begin
            s = "";
            for (int k = 0; k < 260; k++) s = {s, "q"};
            push_str(s); push_str(" ");
          end
          2: push_end();
          default: begin
            push_str(frags[$urandom_range(frags.size() - 1)]);
            if ($urandom_range(1)) push_str(" ");
            if ($urandom_range(4) == 0) begin
              s = ""; s = {s, 8'($urandom_range(48, 57))}; push_str(s);
            end
          end
        endcase
        foreach (send_q[i]) send_item(send_q[i]);
        n += send_q.size();
      end
      push_end();
      send_item(send_q[send_q.size() - 1]);
      in_valid_i <= 1'b0;
      // Hold the sender until every expected result has drained.
      while (pending_tokens.size() != 0) @(posedge clk_i);
    end

    recv_stall = 0;
    for (int w = 0; w < 100000 && pending_tokens.size() != 0; w++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_tokens.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== source_token_lexer.f =====
hdl/stl_pkg.sv
hdl/source_token_lexer.sv
hdl/stl_checker.sv
dv/source_token_lexer_tb.sv
